/* design/lcdw_pkg.sv */
// types and constants shared by the lcd parallel write sequencer
`timescale 1ns / 1ps
package lcdw_pkg;

   // request opcodes
   localparam logic [1:0] OP_CMD    = 2'd0;
   localparam logic [1:0] OP_CHAR   = 2'd1;
   localparam logic [1:0] OP_CURSOR = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_FOUR_BIT_MODE = 2'd0;
   localparam logic [1:0] CSR_NIBBLE_OFFSET = 2'd1;
   localparam logic [1:0] CSR_PHASE_TICKS   = 2'd2;

   localparam int unsigned CSR_DATA_W = 16;

   // csr reset values
   localparam logic        FOUR_BIT_MODE_RST = 1'b0;
   localparam logic [2:0]  NIBBLE_OFFSET_RST = 3'd4;
   localparam logic [15:0] PHASE_TICKS_RST   = 16'd1000;

   // phase indexes of the last pin state
   localparam logic [2:0] LAST_PHASE_8BIT = 3'd3;
   localparam logic [2:0] LAST_PHASE_4BIT = 3'd6;

   localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
   localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] value;
      logic [1:0] row;
      logic [5:0] column;
   } lcdw_req_type;

   typedef struct packed {
      logic        reg_select;
      logic        read_write;
      logic        enable;
      logic [7:0]  data_port;
      logic [15:0] hold_ticks;
      logic        last;
   } lcdw_rsp_type;

   // ddram base address of each display row
   function automatic logic [6:0] row_base(input logic [1:0] row);
      logic [6:0] base;
      case (row)
         2'd0:    base = 7'h00;
         2'd1:    base = 7'h40;
         2'd2:    base = 7'h10;
         2'd3:    base = 7'h50;
         default: base = 7'h00;
      endcase
      return base;
   endfunction

endpackage

/* design/char_lcd_parallel_write_sequencer_top.sv */
// lcd parallel write sequencer: request to timed pin state sequence
`timescale 1ns / 1ps
// the request is first held in the item registers, then each pin state is registered in the output register
// throughput: one pin state per cycle unless rsp_ready stalls the output, 4 per transaction
//   in 8-bit mode, 7 in 4-bit mode, set by the phase counter that walks the held request;
//   the next request is taken while the final pin state issues: transactions run back to back
// reset: synchronous, active high; clears valids, phase counter and pin latches, loads csr reset values
module char_lcd_parallel_write_sequencer_top
   import lcdw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lcdw_req_type          req_data,
   // pin state channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lcdw_rsp_type          rsp_data,
   // csr write port
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // csrs
   logic        four_bit_mode_ff, four_bit_mode_in;
   logic [2:0]  nibble_offset_ff, nibble_offset_in;
   logic [15:0] phase_ticks_ff, phase_ticks_in;

   // held request: the byte to send and its rs level
   logic        item_valid_ff, item_valid_in;
   logic [7:0]  item_byte_ff, item_byte_in;
   logic        item_rs_ff, item_rs_in;
   logic [2:0]  phase_ff, phase_in;

   // pin latches
   logic [7:0]  port_latch_ff, port_latch_in;
   logic        enable_latch_ff, enable_latch_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   lcdw_rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic        advance;
   logic        last_phase;
   logic        req_take;
   logic        req_useful;
   logic [7:0]  req_byte;
   logic        req_rs;
   logic [6:0]  cursor_addr;
   logic [15:0] hold;
   logic [7:0]  nib_mask;
   logic [7:0]  nib_bits;
   logic [3:0]  nib;
   logic        phase_enable;

   // output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid_ff && out_free;
   assign last_phase = four_bit_mode_ff ? (phase_ff == LAST_PHASE_4BIT)
                                        : (phase_ff == LAST_PHASE_8BIT);

   // take a new request when nothing is held or the held one finishes now
   assign req_ready = !item_valid_ff || (advance && last_phase);
   assign req_take  = req_valid && req_ready;

   // decode the request into byte and rs; unused opcode produces nothing
   assign cursor_addr = 7'(req_data.column) + row_base(req_data.row);

   always_comb begin
      req_byte   = req_data.value;
      req_rs     = 1'b0;
      req_useful = 1'b1;
      case (req_data.op)
         OP_CMD: begin
            req_byte = req_data.value;
            req_rs   = 1'b0;
         end
         OP_CHAR: begin
            req_byte = req_data.value;
            req_rs   = 1'b1;
         end
         OP_CURSOR: begin
            req_byte = SET_DDRAM_CMD | {1'b0, cursor_addr};
            req_rs   = 1'b0;
         end
         default: begin
            req_useful = 1'b0;
         end
      endcase
   end

   // a zero hold count is held for one tick
   assign hold = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;

   // nibble placement, bits beyond pin 7 drop off
   assign nib      = (phase_ff == 3'd2) ? item_byte_ff[7:4] : item_byte_ff[3:0];
   assign nib_mask = NIBBLE_MASK << nibble_offset_ff;
   assign nib_bits = {4'b0000, nib} << nibble_offset_ff;

   // per phase: next port level and e level
   always_comb begin
      port_latch_in = port_latch_ff;
      phase_enable  = 1'b0;
      if (four_bit_mode_ff) begin
         // setup, e high, high nibble, e low, e high, low nibble, e low
         case (phase_ff)
            3'd0:    phase_enable = enable_latch_ff;
            3'd1:    phase_enable = 1'b1;
            3'd2: begin
               phase_enable = 1'b1;
               if (advance) port_latch_in = (port_latch_ff & ~nib_mask) | nib_bits;
            end
            3'd3:    phase_enable = 1'b0;
            3'd4:    phase_enable = 1'b1;
            3'd5: begin
               phase_enable = 1'b1;
               if (advance) port_latch_in = (port_latch_ff & ~nib_mask) | nib_bits;
            end
            default: phase_enable = 1'b0;
         endcase
      end else begin
         // setup, e high, data on the port, e low
         case (phase_ff)
            3'd0:    phase_enable = enable_latch_ff;
            3'd1:    phase_enable = 1'b1;
            3'd2: begin
               phase_enable = 1'b1;
               if (advance) port_latch_in = item_byte_ff;
            end
            default: phase_enable = 1'b0;
         endcase
      end
   end

   always_comb begin
      enable_latch_in = advance ? phase_enable : enable_latch_ff;

      // held request and phase counter
      item_valid_in = item_valid_ff;
      item_byte_in  = item_byte_ff;
      item_rs_in    = item_rs_ff;
      phase_in      = phase_ff;
      if (advance) begin
         if (last_phase) begin
            item_valid_in = 1'b0;
            phase_in      = 3'd0;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end
      if (req_take) begin
         item_valid_in = req_useful;
         item_byte_in  = req_byte;
         item_rs_in    = req_rs;
         phase_in      = 3'd0;
      end

      // output register
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.reg_select = item_rs_ff;
         rsp_data_in.read_write = 1'b0;
         rsp_data_in.enable     = phase_enable;
         rsp_data_in.data_port  = port_latch_in;
         rsp_data_in.hold_ticks = hold;
         rsp_data_in.last       = last_phase;
      end

      // csr writes
      four_bit_mode_in = four_bit_mode_ff;
      nibble_offset_in = nibble_offset_ff;
      phase_ticks_in   = phase_ticks_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_FOUR_BIT_MODE: four_bit_mode_in = csr_data[0];
            CSR_NIBBLE_OFFSET: nibble_offset_in = csr_data[2:0];
            CSR_PHASE_TICKS:   phase_ticks_in   = csr_data[15:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_mode_ff <= FOUR_BIT_MODE_RST;
         nibble_offset_ff <= NIBBLE_OFFSET_RST;
         phase_ticks_ff   <= PHASE_TICKS_RST;
         item_valid_ff    <= 1'b0;
         phase_ff         <= 3'd0;
         port_latch_ff    <= 8'd0;
         enable_latch_ff  <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         four_bit_mode_ff <= four_bit_mode_in;
         nibble_offset_ff <= nibble_offset_in;
         phase_ticks_ff   <= phase_ticks_in;
         item_valid_ff    <= item_valid_in;
         phase_ff         <= phase_in;
         port_latch_ff    <= port_latch_in;
         enable_latch_ff  <= enable_latch_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_byte_ff <= item_byte_in;
      item_rs_ff   <= item_rs_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
